FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the ARP cache design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on the rising edge of the given clock, held off during reset.
`define ARPC_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ARP cache check failed");

// Same check on the block's own clock and reset.
`define ARPC_ASSERT(lbl, prop) \
    `ARPC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`else

`define ARPC_ASSERT_CLK(lbl, clk, rst_n, prop)
`define ARPC_ASSERT(lbl, prop)

`endif

`endif

FILE: design/arpc_pkg.sv
// ---------------------------------------------------------------------------
// ARP cache package
// Widths, codes, defaults and the sequencer state type of the ARP cache.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int unsigned DEF_CACHE_ENTRIES = 16;
    localparam int unsigned DEF_PENDING_SLOTS = 8;

    localparam int unsigned IP_W   = 32;
    localparam int unsigned MAC_W  = 48;
    localparam int unsigned HW_W   = 16;
    localparam int unsigned OPER_W = 16;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned TXOP_W = 2;

    localparam int unsigned IN_TDATA_W  = 224;
    localparam int unsigned OUT_TDATA_W = 216;
    localparam int unsigned CFG_W       = MAC_W;

    // Configuration register indexes
    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    // Input opcodes
    localparam logic OPC_RESOLVE = 1'b0;
    localparam logic OPC_RECEIVE = 1'b1;

    // ARP header codes
    localparam logic [HW_W-1:0]   HTYPE_ETH = 16'd1;
    localparam logic [OPER_W-1:0] OPER_REQ  = 16'd1;
    localparam logic [OPER_W-1:0] OPER_REP  = 16'd2;

    localparam logic [TXOP_W-1:0] TXOP_NONE = 2'd0;
    localparam logic [TXOP_W-1:0] TXOP_REQ  = 2'd1;
    localparam logic [TXOP_W-1:0] TXOP_REP  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HIT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEND_REQ = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEND_REP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;

    localparam logic [7:0]       BCAST_BYTE = 8'hFF;
    localparam logic [MAC_W-1:0] BCAST_MAC  = {6{BCAST_BYTE}};

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CSCAN = 4'b0010,
        S_PSCAN = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

endpackage

FILE: design/arpc_ram.sv
// ---------------------------------------------------------------------------
// ARP cache RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/arp_cache_and_responder_core.sv
// ---------------------------------------------------------------------------
// ARP cache and responder core
// Resolves IPv4 addresses through a bounded cache, tracks pending requests
// and answers or absorbs received ARP packets.
// ---------------------------------------------------------------------------
// The block takes one word at a time and holds s_axis_tready low until that
// word is finished. Cache and pending lookups all go through one 32-bit
// comparator that walks the cache memory and the pending memory, one entry
// per cycle; the checks against our own addresses are made as a word is
// accepted. A resolve walks the cache up to a hit and, on a miss, the pending
// memory for a free slot. A reply for our MAC address walks the pending
// memory and, when it fulfils a slot, then the cache; a request for our
// address and an ignored packet need no walk. A finished result may wait on
// a full output register. Results sit in an output register, so a result
// waiting on m_axis_tready does not stop the next word being accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arp_cache_and_responder_core
    import arpc_pkg::*;
#(
    parameter int unsigned CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int unsigned PENDING_SLOTS = DEF_PENDING_SLOTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // lookup_ip, hw_type, arp_oper, sender_mac, sender_ip, target_mac, target_ip
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [0:0]             s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // found_ip, found_mac, tx_oper, tx_dest_mac, tx_target_mac, tx_target_ip, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic [KIND_W-1:0]      m_axis_tuser
);

    localparam int unsigned CIW = $clog2(CACHE_ENTRIES);
    localparam int unsigned CCW = $clog2(CACHE_ENTRIES + 1);
    localparam int unsigned PIW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int unsigned PCW = $clog2(PENDING_SLOTS + 1);
    localparam int unsigned CWW = IP_W + MAC_W;
    localparam int unsigned PAD_W = OUT_TDATA_W - (2 * IP_W + 3 * MAC_W + TXOP_W);

    // input fields
    logic                in_opcode;
    logic [IP_W-1:0]     in_lookup_ip;
    logic [HW_W-1:0]     in_hw_type;
    logic [OPER_W-1:0]   in_arp_oper;
    logic [MAC_W-1:0]    in_sender_mac;
    logic [IP_W-1:0]     in_sender_ip;
    logic [MAC_W-1:0]    in_target_mac;
    logic [IP_W-1:0]     in_target_ip;

    assign in_opcode     = s_axis_tuser[0];
    assign in_lookup_ip  = s_axis_tdata[31:0];
    assign in_hw_type    = s_axis_tdata[47:32];
    assign in_arp_oper   = s_axis_tdata[63:48];
    assign in_sender_mac = s_axis_tdata[111:64];
    assign in_sender_ip  = s_axis_tdata[143:112];
    assign in_target_mac = s_axis_tdata[191:144];
    assign in_target_ip  = s_axis_tdata[223:192];

    // registers
    t_state                   r_state, n_state;
    logic                     r_store, n_store;
    logic                     r_free, n_free;
    logic [IP_W-1:0]          r_key, n_key;
    logic [MAC_W-1:0]         r_smac, n_smac;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic [CCW-1:0]           r_cidx, n_cidx;
    logic [PCW-1:0]           r_pidx, n_pidx;
    logic [CIW-1:0]           r_rptr, n_rptr;
    logic [CACHE_ENTRIES-1:0] r_cvalid, n_cvalid;
    logic [PENDING_SLOTS-1:0] r_pvalid, n_pvalid;
    logic                     r_c_chk;
    logic [CIW-1:0]           r_c_at;
    logic                     r_p_chk;
    logic                     r_p_vld;
    logic [PIW-1:0]           r_p_at;
    logic [MAC_W-1:0]         r_own_mac;
    logic [IP_W-1:0]          r_own_ip;
    logic                     r_m_valid;
    logic [KIND_W-1:0]        r_m_kind;
    logic [OUT_TDATA_W-1:0]   r_m_data;

    // memory ports
    logic                     c_we;
    logic [CIW-1:0]           c_waddr;
    logic [CWW-1:0]           c_wdata;
    logic [CWW-1:0]           c_rd;
    logic                     p_we;
    logic [IP_W-1:0]          p_rd;

    logic                     s_acc;
    logic [IP_W-1:0]          cmp_ip;
    logic                     key_eq;
    logic                     c_hit;
    logic                     c_end;
    logic                     p_hit;
    logic                     p_end;
    logic                     out_load;
    logic [OUT_TDATA_W-1:0]   res_data;

    arpc_ram #(
        .DEPTH (CACHE_ENTRIES),
        .WIDTH (CWW),
        .AW    (CIW)
    ) u_cache_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (r_cidx[CIW-1:0]),
        .o_rdata (c_rd)
    );

    arpc_ram #(
        .DEPTH (PENDING_SLOTS),
        .WIDTH (IP_W),
        .AW    (PIW)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_p_at),
        .i_wdata (r_key),
        .i_raddr (r_pidx[PIW-1:0]),
        .o_rdata (p_rd)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // The one address comparator, shared by both scans.
    assign cmp_ip = (r_state == S_PSCAN) ? p_rd : c_rd[IP_W-1:0];
    assign key_eq = (cmp_ip == r_key);

    assign c_hit = r_c_chk && key_eq;
    assign c_end = (r_cidx == CCW'(CACHE_ENTRIES));
    assign p_hit = r_p_chk && (r_free ? !r_p_vld : (r_p_vld && key_eq));
    assign p_end = (r_pidx == PCW'(PENDING_SLOTS));

    assign out_load = (r_state == S_PUSH) && (!r_m_valid || m_axis_tready);
    assign c_wdata  = {r_smac, r_key};

    always_comb begin
        n_state  = r_state;
        n_store  = r_store;
        n_free   = r_free;
        n_key    = r_key;
        n_smac   = r_smac;
        n_kind   = r_kind;
        n_cidx   = r_cidx;
        n_pidx   = r_pidx;
        n_rptr   = r_rptr;
        n_cvalid = r_cvalid;
        n_pvalid = r_pvalid;
        c_we     = 1'b0;
        c_waddr  = r_rptr;
        p_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_key   = (in_opcode == OPC_RECEIVE) ? in_sender_ip : in_lookup_ip;
                    n_smac  = in_sender_mac;
                    n_cidx  = '0;
                    n_pidx  = '0;
                    n_store = 1'b0;
                    n_free  = 1'b0;
                    priority if (in_opcode == OPC_RESOLVE) begin
                        n_state = S_CSCAN;
                    end else if (in_hw_type == HTYPE_ETH && in_arp_oper == OPER_REQ
                                 && in_target_ip == r_own_ip) begin
                        n_kind  = KIND_SEND_REP;
                        n_state = S_PUSH;
                    end else if (in_hw_type == HTYPE_ETH && in_arp_oper == OPER_REP
                                 && in_target_mac == r_own_mac) begin
                        n_state = S_PSCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CSCAN: begin
                if (c_hit || c_end) begin
                    if (r_store) begin
                        // Store the reply: refresh the MAC in place if cached, else write at r_rptr.
                        c_we = 1'b1;
                        if (c_hit) begin
                            c_waddr = r_c_at;
                        end else begin
                            n_cvalid[r_rptr] = 1'b1;
                            n_rptr = (r_rptr == CIW'(CACHE_ENTRIES - 1)) ? '0 : r_rptr + 1'b1;
                        end
                        n_kind  = KIND_DONE;
                        n_state = S_PUSH;
                    end else if (c_hit) begin
                        n_smac  = c_rd[CWW-1:IP_W];
                        n_kind  = KIND_HIT;
                        n_state = S_PUSH;
                    end else begin
                        n_free  = 1'b1;
                        n_pidx  = '0;
                        n_state = S_PSCAN;
                    end
                end else begin
                    n_cidx = r_cidx + 1'b1;
                end
            end
            S_PSCAN: begin
                if (p_hit) begin
                    if (r_free) begin
                        p_we             = 1'b1;
                        n_pvalid[r_p_at] = 1'b1;
                        n_kind           = KIND_SEND_REQ;
                        n_state          = S_PUSH;
                    end else begin
                        n_pvalid[r_p_at] = 1'b0;
                        n_store          = 1'b1;
                        n_cidx           = '0;
                        n_state          = S_CSCAN;
                    end
                end else if (p_end) begin
                    if (r_free) begin
                        n_kind  = KIND_FULL;
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_pidx = r_pidx + 1'b1;
                end
            end
            S_PUSH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result word built from the kind and the held key and MAC.
    always_comb begin
        logic [IP_W-1:0]   f_ip;
        logic [MAC_W-1:0]  f_mac;
        logic [TXOP_W-1:0] t_op;
        logic [MAC_W-1:0]  t_dmac;
        logic [MAC_W-1:0]  t_tmac;
        logic [IP_W-1:0]   t_ip;
        f_ip   = '0;
        f_mac  = '0;
        t_op   = TXOP_NONE;
        t_dmac = '0;
        t_tmac = '0;
        t_ip   = '0;
        unique case (r_kind)
            KIND_HIT, KIND_DONE: begin
                f_ip  = r_key;
                f_mac = r_smac;
            end
            KIND_SEND_REQ: begin
                t_op   = TXOP_REQ;
                t_dmac = BCAST_MAC;
                t_tmac = BCAST_MAC;
                t_ip   = r_key;
            end
            KIND_SEND_REP: begin
                t_op   = TXOP_REP;
                t_dmac = r_smac;
                t_tmac = r_smac;
                t_ip   = r_key;
            end
            default: begin
                f_ip = '0;
            end
        endcase
        res_data = {PAD_W'(0), t_ip, t_tmac, t_dmac, t_op, f_mac, f_ip};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_store   <= 1'b0;
            r_free    <= 1'b0;
            r_cidx    <= '0;
            r_pidx    <= '0;
            r_rptr    <= '0;
            r_cvalid  <= '0;
            r_pvalid  <= '0;
            r_c_chk   <= 1'b0;
            r_p_chk   <= 1'b0;
            r_own_mac <= '0;
            r_own_ip  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_store  <= n_store;
            r_free   <= n_free;
            r_cidx   <= n_cidx;
            r_pidx   <= n_pidx;
            r_rptr   <= n_rptr;
            r_cvalid <= n_cvalid;
            r_pvalid <= n_pvalid;
            // Qualifiers are registered alongside the memory read data.
            r_c_chk  <= (r_state == S_CSCAN) && (r_cidx < CCW'(CACHE_ENTRIES))
                        && r_cvalid[r_cidx[CIW-1:0]];
            r_p_chk  <= (r_state == S_PSCAN) && (r_pidx < PCW'(PENDING_SLOTS));
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_OWN_MAC) begin
                    r_own_mac <= i_cfg_wdata[MAC_W-1:0];
                end else begin
                    r_own_ip <= i_cfg_wdata[IP_W-1:0];
                end
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_smac <= n_smac;
        r_kind <= n_kind;
        r_c_at <= r_cidx[CIW-1:0];
        r_p_at <= r_pidx[PIW-1:0];
        r_p_vld <= r_pvalid[r_pidx[PIW-1:0]];
        if (out_load) begin
            r_m_kind <= r_kind;
            r_m_data <= res_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

    `ARPC_ASSERT(a_resolve_scans_cache, (s_acc && in_opcode == OPC_RESOLVE) |=> (r_state == S_CSCAN))
    `ARPC_ASSERT(a_rptr_moves_on_store, !$stable(r_rptr) |-> $past(r_state == S_CSCAN && r_store))
    `ARPC_ASSERT(a_pvalid_moves_in_pscan, !$stable(r_pvalid) |-> $past(r_state == S_PSCAN))
    `ARPC_ASSERT(a_result_from_push, $rose(r_m_valid) |-> $past(r_state == S_PUSH))

endmodule

FILE: dv/arp_cache_and_responder_core_tb.sv
// ---------------------------------------------------------------------------
// ARP cache and responder core testbench
// Drives resolve and received-packet words into the core under random
// handshake gaps and checks every result word against an in-bench predictor
// of the cache, the pending slots and the responder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_cache_and_responder_core_tb;
    import arpc_pkg::*;

    localparam int CACHE_N     = DEF_CACHE_ENTRIES;
    localparam int PEND_N      = DEF_PENDING_SLOTS;
    localparam int POOL_N      = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic              opc;
        logic [IP_W-1:0]   lookup_ip;
        logic [HW_W-1:0]   hw_type;
        logic [OPER_W-1:0] oper;
        logic [MAC_W-1:0]  smac;
        logic [IP_W-1:0]   sip;
        logic [MAC_W-1:0]  tmac;
        logic [IP_W-1:0]   tip;
    } t_arp_word;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IP_W-1:0]   found_ip;
        logic [MAC_W-1:0]  found_mac;
        logic [TXOP_W-1:0] tx_oper;
        logic [MAC_W-1:0]  dest_mac;
        logic [MAC_W-1:0]  tgt_mac;
        logic [IP_W-1:0]   tgt_ip;
    } t_arp_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_addr;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;

    // Predicted state of the core.
    logic [MAC_W-1:0] own_mac_m;
    logic [IP_W-1:0]  own_ip_m;
    logic [IP_W-1:0]  cache_ip_m  [CACHE_N];
    logic [MAC_W-1:0] cache_mac_m [CACHE_N];
    bit               cache_live  [CACHE_N];
    int               replace_at;
    logic [IP_W-1:0]  pend_ip_m   [PEND_N];
    bit               pend_live   [PEND_N];

    t_arp_result      arp_answers_due [$];
    logic [IP_W-1:0]  ip_pool [POOL_N];

    int fail_count;
    int cycle_count;
    int results_taken;
    int hold_reqs;
    bit steady;

    arp_cache_and_responder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL arp_cache_and_responder_core");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    task automatic store_in_cache(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        int i;
        int found;
        found = -1;
        for (i = 0; i < CACHE_N; i++)
            if (found < 0 && cache_live[i] && cache_ip_m[i] == ip) found = i;
        if (found >= 0) begin
            cache_mac_m[found] = mac;
        end else begin
            cache_ip_m[replace_at]  = ip;
            cache_mac_m[replace_at] = mac;
            cache_live[replace_at]  = 1'b1;
            replace_at = (replace_at + 1) % CACHE_N;
        end
    endtask

    task automatic predict_arp(input t_arp_word w, output bit produced, output t_arp_result r);
        int i;
        int slot;
        bit hit;
        r        = '0;
        produced = 1'b0;
        slot     = -1;
        hit      = 1'b0;
        if (w.opc == OPC_RESOLVE) begin
            produced = 1'b1;
            for (i = 0; i < CACHE_N; i++) begin
                if (!hit && cache_live[i] && cache_ip_m[i] == w.lookup_ip) begin
                    hit         = 1'b1;
                    r.kind      = KIND_HIT;
                    r.found_ip  = w.lookup_ip;
                    r.found_mac = cache_mac_m[i];
                end
            end
            if (!hit) begin
                for (i = 0; i < PEND_N; i++)
                    if (slot < 0 && !pend_live[i]) slot = i;
                if (slot < 0) begin
                    r.kind = KIND_FULL;
                end else begin
                    pend_live[slot] = 1'b1;
                    pend_ip_m[slot] = w.lookup_ip;
                    r.kind     = KIND_SEND_REQ;
                    r.tx_oper  = TXOP_REQ;
                    r.dest_mac = BCAST_MAC;
                    r.tgt_mac  = BCAST_MAC;
                    r.tgt_ip   = w.lookup_ip;
                end
            end
        end else if (w.hw_type == HTYPE_ETH) begin
            if (w.oper == OPER_REQ && w.tip == own_ip_m) begin
                produced   = 1'b1;
                r.kind     = KIND_SEND_REP;
                r.tx_oper  = TXOP_REP;
                r.dest_mac = w.smac;
                r.tgt_mac  = w.smac;
                r.tgt_ip   = w.sip;
            end else if (w.oper == OPER_REP && w.tmac == own_mac_m) begin
                // Only the lowest pending slot for this address is released.
                for (i = 0; i < PEND_N; i++)
                    if (slot < 0 && pend_live[i] && pend_ip_m[i] == w.sip) slot = i;
                if (slot >= 0) begin
                    pend_live[slot] = 1'b0;
                    store_in_cache(w.sip, w.smac);
                    produced    = 1'b1;
                    r.kind      = KIND_DONE;
                    r.found_ip  = w.sip;
                    r.found_mac = w.smac;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_OWN_MAC) own_mac_m = value[MAC_W-1:0];
        else                    own_ip_m  = value[IP_W-1:0];
    endtask

    // Sends one word; tvalid is left high so that a following word with no gap
    // goes out back to back. Every caller moves on to another send or to settle.
    task automatic send_word(input t_arp_word w);
        int gap;
        bit produced;
        t_arp_result r;
        gap = steady ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {w.tip, w.tmac, w.sip, w.smac, w.oper, w.hw_type, w.lookup_ip};
        s_axis_tuser  = w.opc;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_arp(w, produced, r);
        if (produced) arp_answers_due.push_back(r);
    endtask

    // Waits until the core is idle: no word offered, no result owed, and time
    // for a word that produces nothing to finish its scan.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (arp_answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic t_arp_word resolve_word(input logic [IP_W-1:0] ip);
        t_arp_word w;
        w = {1'b0, ip, 16'($urandom), 16'($urandom), rand_mac(), 32'($urandom),
             rand_mac(), 32'($urandom)};
        w.opc = OPC_RESOLVE;
        return w;
    endfunction

    function automatic t_arp_word rx_word(input logic [OPER_W-1:0] oper,
                                          input logic [HW_W-1:0] hw,
                                          input logic [MAC_W-1:0] smac,
                                          input logic [IP_W-1:0] sip,
                                          input logic [MAC_W-1:0] tmac,
                                          input logic [IP_W-1:0] tip);
        t_arp_word w;
        w = {OPC_RECEIVE, 32'($urandom), hw, oper, smac, sip, tmac, tip};
        return w;
    endfunction

    task automatic make_random_word(output t_arp_word w);
        int pick;
        int slot;
        int live [$];
        for (int i = 0; i < PEND_N; i++)
            if (pend_live[i]) live.push_back(i);
        pick = $urandom_range(0, 99);
        // A reply can only be useful while something is pending.
        if (pick >= 40 && pick < 70 && live.size() == 0) pick = 0;
        if (pick < 40) begin
            w = resolve_word(($urandom_range(0, 9) != 0) ? ip_pool[$urandom_range(0, POOL_N-1)]
                                                         : 32'($urandom));
        end else if (pick < 70) begin
            slot = live[$urandom_range(0, live.size()-1)];
            w = rx_word(OPER_REP, HTYPE_ETH, rand_mac(), pend_ip_m[slot], own_mac_m,
                        32'($urandom));
        end else if (pick < 80) begin
            w = rx_word(OPER_REQ, HTYPE_ETH, rand_mac(), 32'($urandom), rand_mac(),
                        ($urandom_range(0, 3) != 0) ? own_ip_m : 32'($urandom));
        end else begin
            w = rx_word(16'($urandom), 16'($urandom), rand_mac(), 32'($urandom),
                        rand_mac(), 32'($urandom));
            case ($urandom_range(0, 3))
                0: begin
                    w.hw_type = 16'($urandom);
                end
                1: begin
                    w.hw_type = HTYPE_ETH;
                end
                2: begin
                    // Reply addressed to someone else.
                    w.hw_type = HTYPE_ETH;
                    w.oper    = OPER_REP;
                    w.sip     = ip_pool[$urandom_range(0, POOL_N-1)];
                    w.tmac    = own_mac_m ^ (rand_mac() | 48'h1);
                end
                default: begin
                    // Reply for us, often for an address nobody asked for.
                    w.hw_type = HTYPE_ETH;
                    w.oper    = OPER_REP;
                    w.tmac    = own_mac_m;
                    w.sip     = ip_pool[$urandom_range(0, POOL_N-1)];
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin
        int hold_seen;
        int hold_left;
        int taken_seen;
        int rx_wait;
        hold_seen  = 0;
        hold_left  = 0;
        taken_seen = 0;
        rx_wait    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (taken_seen != results_taken) begin
                taken_seen = results_taken;
                rx_wait    = steady ? 0 : $urandom_range(0, 10);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_arp_result got;
        t_arp_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind      = m_axis_tuser;
            got.found_ip  = m_axis_tdata[31:0];
            got.found_mac = m_axis_tdata[79:32];
            got.tx_oper   = m_axis_tdata[81:80];
            got.dest_mac  = m_axis_tdata[129:82];
            got.tgt_mac   = m_axis_tdata[177:130];
            got.tgt_ip    = m_axis_tdata[209:178];
            if (arp_answers_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got kind %0d",
                         $time, got.kind);
                fail_count++;
            end else begin
                want = arp_answers_due.pop_front();
                check_field("result_kind", want.kind, got.kind);
                check_field("found_ip", want.found_ip, got.found_ip);
                check_field("found_mac", want.found_mac, got.found_mac);
                check_field("tx_oper", want.tx_oper, got.tx_oper);
                check_field("tx_dest_mac", want.dest_mac, got.dest_mac);
                check_field("tx_target_mac", want.tgt_mac, got.tgt_mac);
                check_field("tx_target_ip", want.tgt_ip, got.tgt_ip);
            end
            results_taken++;
        end
    end

    // ---------------------------------------------------------------- tests

    // Own addresses are zero out of reset.
    task automatic test_reset_identity();
        send_word(rx_word(OPER_REQ, HTYPE_ETH, rand_mac(), 32'($urandom), rand_mac(), '0));
        send_word(rx_word(OPER_REP, HTYPE_ETH, rand_mac(), 32'($urandom), '0, 32'($urandom)));
    endtask

    task automatic test_resolve_and_fulfil();
        settle();
        write_reg(CFG_OWN_MAC, BCAST_MAC);
        write_reg(CFG_OWN_IP, {16'h0, 32'hFFFF_FFFF});
        send_word(resolve_word('0));
        send_word(resolve_word('0));              // same address pending twice
        send_word(resolve_word(32'hFFFF_FFFF));
        repeat (5) send_word(resolve_word(32'($urandom)));
        send_word(resolve_word(32'($urandom)));   // all slots taken
        send_word(rx_word(OPER_REP, HTYPE_ETH, '0, '0, own_mac_m, 32'($urandom)));
        send_word(rx_word(OPER_REP, HTYPE_ETH, BCAST_MAC, '0, own_mac_m, 32'($urandom)));
        send_word(resolve_word('0));
        send_word(rx_word(OPER_REP, HTYPE_ETH, rand_mac(), 32'hFFFF_FFFF, own_mac_m, '0));
        send_word(resolve_word(32'hFFFF_FFFF));
    endtask

    task automatic test_ignored_packets();
        send_word(rx_word(OPER_REP, HTYPE_ETH, rand_mac(), pend_ip_m[3], '0, 32'($urandom)));
        send_word(rx_word(OPER_REP, HTYPE_ETH, rand_mac(), '0, own_mac_m, 32'($urandom)));
        send_word(rx_word(OPER_REQ, 16'h0000, rand_mac(), 32'($urandom), rand_mac(), own_ip_m));
        send_word(rx_word(OPER_REQ, 16'hFFFF, rand_mac(), 32'($urandom), rand_mac(), own_ip_m));
        send_word(rx_word(OPER_REQ, HTYPE_ETH, rand_mac(), 32'($urandom), rand_mac(), '0));
        send_word(rx_word(OPER_REQ, HTYPE_ETH, BCAST_MAC, '0, '0, own_ip_m));
        send_word(rx_word(16'h0000, HTYPE_ETH, rand_mac(), 32'($urandom), own_mac_m, own_ip_m));
        send_word(rx_word(16'h0003, HTYPE_ETH, rand_mac(), 32'($urandom), own_mac_m, own_ip_m));
        send_word(rx_word(16'hFFFF, HTYPE_ETH, rand_mac(), 32'($urandom), own_mac_m, own_ip_m));
    endtask

    task automatic test_random_traffic(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip,
                                       input int count);
        t_arp_word w;
        settle();
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_OWN_IP, {16'h0, ip});
        // More addresses than cache entries, so replacement wraps.
        ip_pool[0] = '0;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_N; i++) ip_pool[i] = $urandom;
        for (int i = 0; i < count; i++) begin
            steady = ((i / 40) % 4) == 3;
            make_random_word(w);
            send_word(w);
        end
        steady = 1'b0;
    endtask

    // The receiver stops for a long while; the core fills its output register
    // and then has to hold off further words.
    task automatic test_backpressure();
        t_arp_word w;
        hold_reqs++;
        steady = 1'b1;
        repeat (30) begin
            make_random_word(w);
            send_word(w);
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_OWN_MAC;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OPC_RESOLVE;
        steady        = 1'b0;
        hold_reqs     = 0;
        fail_count    = 0;
        cycle_count   = 0;
        results_taken = 0;
        own_mac_m     = '0;
        own_ip_m      = '0;
        replace_at    = 0;
        for (int i = 0; i < CACHE_N; i++) begin
            cache_ip_m[i]  = '0;
            cache_mac_m[i] = '0;
            cache_live[i]  = 1'b0;
        end
        for (int i = 0; i < PEND_N; i++) begin
            pend_ip_m[i] = '0;
            pend_live[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_identity();
        test_resolve_and_fulfil();
        test_ignored_packets();
        test_random_traffic(rand_mac(), $urandom, 220);
        test_backpressure();
        test_random_traffic('0, '0, 220);
        test_random_traffic(BCAST_MAC, 32'hFFFF_FFFF, 220);
        test_random_traffic(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 220);
        test_random_traffic(rand_mac(), $urandom, 220);

        settle();
        if (fail_count == 0) begin
            $display("PASS arp_cache_and_responder_core");
        end else begin
            $display("FAIL arp_cache_and_responder_core");
        end
        $finish;
    end

endmodule
